// ----- rtl/kbm_pkg.sv -----
// Shared types, constants and envelope helper for the keypress beep mixer.
package kbm_pkg;

  // Beep timing and level
  localparam int HALF_PERIOD = 20;
  localparam int BEEP_LENGTH = 2400;
  localparam int FADE_LENGTH = 240;
  localparam int PEAK_LEVEL  = 6000;

  // Widths: the sample width, and widths derived from the timing and level constants
  localparam int SMP_W = 16;
  localparam int SR_W  = $clog2(BEEP_LENGTH + 1);
  localparam int HP_W  = $clog2(HALF_PERIOD + 1);
  localparam int ENV_W = $clog2(FADE_LENGTH + 1);
  localparam int FR_W  = $clog2(FADE_LENGTH + 1);
  localparam int MAG_W = $clog2(PEAK_LEVEL + 1);

  // Level step per envelope unit: quotient and remainder of PEAK / FADE
  localparam logic [MAG_W-1:0] Q_INC   = MAG_W'(PEAK_LEVEL / FADE_LENGTH);
  localparam logic [FR_W-1:0]  R_INC   = FR_W'(PEAK_LEVEL % FADE_LENGTH);
  localparam logic [FR_W-1:0]  FADE_FR = FR_W'(FADE_LENGTH);

  localparam logic [SR_W-1:0]  SR_START  = SR_W'(BEEP_LENGTH);
  localparam logic [HP_W-1:0]  HP_RELOAD = HP_W'(HALF_PERIOD - 1);

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  // One input transfer
  typedef struct packed {
    logic                    start_beep;
    logic signed [SMP_W-1:0] left_in;
    logic signed [SMP_W-1:0] right_in;
  } kbm_in_t;

  // One result transfer
  typedef struct packed {
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;
    logic                    beep_active;
  } kbm_out_t;

  // Tone generator to mixer
  typedef struct packed {
    logic                    active;
    logic signed [SMP_W-1:0] level;
  } kbm_tone_t;

  // Trapezoid envelope for a given count of samples remaining
  function automatic logic [ENV_W-1:0] kbm_env(input logic [SR_W-1:0] s);
    logic [SR_W-1:0] elapsed;
    logic [SR_W-1:0] env;
    elapsed = (s <= SR_START) ? (SR_START - s) : '0;
    env     = (elapsed < s) ? elapsed : s;
    if (env > SR_W'(FADE_LENGTH) && FADE_LENGTH < (1 << SR_W)) begin
      return ENV_W'(FADE_LENGTH);
    end
    return ENV_W'(env);
  endfunction

endpackage

// ----- rtl/kbm_tone.sv -----
// Beep state: duration counter, square wave phase and incremental envelope level.
module kbm_tone import kbm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  logic      start_beep,
  output kbm_tone_t tone
);

  logic [SR_W-1:0]  sr_r,  sr_nxt;
  logic [HP_W-1:0]  hp_r,  hp_nxt;
  logic             pol_r, pol_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [FR_W-1:0]  rem_r, rem_nxt;

  logic [SR_W-1:0]  sr_cur;
  logic [HP_W-1:0]  hp_cur;
  logic             pol_cur;
  logic [MAG_W-1:0] mag_cur;
  logic [FR_W-1:0]  rem_cur;
  logic             active;
  logic [ENV_W-1:0] env_now, env_next;
  logic [FR_W:0]    rem_up, rem_dn;
  logic [SMP_W-1:0] mag_ext;

  // A start restarts everything before the sample is handled
  always_comb begin
    sr_cur  = start_beep ? SR_START : sr_r;
    hp_cur  = start_beep ? '0 : hp_r;
    pol_cur = start_beep ? 1'b0 : pol_r;
    mag_cur = start_beep ? '0 : mag_r;
    rem_cur = start_beep ? '0 : rem_r;
    active  = (sr_cur != '0);
  end

  // Square wave phase
  always_comb begin
    pol_nxt = pol_cur;
    hp_nxt  = hp_cur;
    if (active) begin
      if (hp_cur == '0) begin
        pol_nxt = ~pol_cur;
        hp_nxt  = HP_RELOAD;
      end else begin
        hp_nxt = hp_cur - 1'b1;
      end
    end
  end

  // Level tracks PEAK*env/FADE as quotient and remainder; env moves by at most one
  always_comb begin
    env_now  = kbm_env(sr_cur);
    env_next = kbm_env(sr_cur - 1'b1);
    rem_up   = {1'b0, rem_cur} + {1'b0, R_INC};
    rem_dn   = {1'b0, rem_cur} - {1'b0, R_INC};
    mag_nxt  = mag_cur;
    rem_nxt  = rem_cur;
    sr_nxt   = sr_cur;
    if (active) begin
      sr_nxt = sr_cur - 1'b1;
      if (env_next > env_now) begin
        if (rem_up >= {1'b0, FADE_FR}) begin
          rem_nxt = FR_W'(rem_up - {1'b0, FADE_FR});
          mag_nxt = mag_cur + Q_INC + 1'b1;
        end else begin
          rem_nxt = rem_up[FR_W-1:0];
          mag_nxt = mag_cur + Q_INC;
        end
      end else if (env_next < env_now) begin
        if (rem_cur < R_INC) begin
          rem_nxt = FR_W'(rem_dn + {1'b0, FADE_FR});
          mag_nxt = mag_cur - Q_INC - 1'b1;
        end else begin
          rem_nxt = rem_dn[FR_W-1:0];
          mag_nxt = mag_cur - Q_INC;
        end
      end
    end
  end

  // Signed tone level for this sample
  always_comb begin
    mag_ext     = SMP_W'(mag_cur);
    tone.active = active;
    tone.level  = pol_nxt ? signed'(mag_ext) : -signed'(mag_ext);
  end

  // State register, updated once per handled sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r  <= '0;
      hp_r  <= '0;
      pol_r <= 1'b0;
      mag_r <= '0;
      rem_r <= '0;
    end else if (advance) begin
      sr_r  <= sr_nxt;
      hp_r  <= hp_nxt;
      pol_r <= pol_nxt;
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// ----- rtl/kbm_mix.sv -----
// Muting and saturating addition of the beep tone to both channels.
module kbm_mix import kbm_pkg::*; (
  input  kbm_in_t   smp,
  input  logic      muted,
  input  kbm_tone_t tone,
  output kbm_out_t  result
);

  logic signed [SMP_W-1:0] left_src, right_src, add;
  logic signed [SMP_W:0]   left_sum, right_sum;

  // Muted input becomes silence; an idle beep adds nothing
  always_comb begin
    left_src  = muted ? '0 : smp.left_in;
    right_src = muted ? '0 : smp.right_in;
    add       = tone.active ? tone.level : '0;
    left_sum  = {left_src[SMP_W-1], left_src} + {add[SMP_W-1], add};
    right_sum = {right_src[SMP_W-1], right_src} + {add[SMP_W-1], add};
  end

  // Clamp to 16 bits when the two top bits disagree
  always_comb begin
    if (left_sum[SMP_W] != left_sum[SMP_W-1]) begin
      result.left_out = left_sum[SMP_W] ? SMP_MIN : SMP_MAX;
    end else begin
      result.left_out = left_sum[SMP_W-1:0];
    end
    if (right_sum[SMP_W] != right_sum[SMP_W-1]) begin
      result.right_out = right_sum[SMP_W] ? SMP_MIN : SMP_MAX;
    end else begin
      result.right_out = right_sum[SMP_W-1:0];
    end
    result.beep_active = tone.active;
  end

endmodule

// ----- rtl/keypress_beep_mixer.sv -----
// Top level of the keypress beep mixer: transfer registers, mute register, tone and mixer.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one stereo sample
//   and a start flag per transfer. A set start flag restarts the beep before
//   that sample is mixed. Result channel (out_valid / out_stall / out_data)
//   returns exactly one mixed, saturated sample per input transfer, in order.
//   cfg_wr_en / cfg_wr_data write the mute bit; write it only while idle.
// Timing:
//   One input register, then the beep state update and mixing between that
//   register and the result register. One transfer is accepted every cycle
//   while the result side keeps up.
// Reset:
//   rst_n (synchronous, active low) clears both pipeline valids, the mute bit
//   and the beep state, so no beep is playing after reset.
// Stall:
//   When out_stall holds a waiting result, the input register keeps its sample
//   and in_stall rises only if that register is also full; beep state advances
//   only when a sample moves into the result register.
module keypress_beep_mixer import kbm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kbm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output kbm_out_t out_data,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  logic      s1_valid_r;
  kbm_in_t   s1_data_r;
  logic      out_valid_r;
  kbm_out_t  out_data_r;
  logic      muted_r;
  logic      out_free;
  logic      advance;
  kbm_tone_t tone;
  kbm_out_t  mix_result;

  // Handshake: result register frees when empty or being taken
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  kbm_tone u_tone (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .start_beep (s1_data_r.start_beep),
    .tone       (tone)
  );

  kbm_mix u_mix (
    .smp    (s1_data_r),
    .muted  (muted_r),
    .tone   (tone),
    .result (mix_result)
  );

  // Control: valids and mute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      muted_r     <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_wr_en) begin
        muted_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= mix_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
